[sv/clns_pkg.sv]
// ----------------------------------------------------------------------------
// clns_pkg
// Types, constants and the power-on strobe table shared by the character LCD
// nibble sequencer modules.
// ----------------------------------------------------------------------------
package clns_pkg;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_INIT    = 2'd1;
    localparam logic [1:0] KIND_CURSOR  = 2'd2;
    localparam logic [1:0] KIND_DISPLAY = 2'd3;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DISP_CTL = 8'h08;
    localparam logic [6:0] ROW_OFFSET   = 7'h40;
    localparam logic [2:0] DC_DISP_ON   = 3'h4;
    localparam logic [2:0] DC_KEEP_MASK = 3'h3;

    localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
    localparam logic [15:0] WAIT_NONE_B   = 16'd0;
    localparam logic [12:0] WAIT_BASE     = 13'd100;
    localparam logic [12:0] WAIT_LONG     = 13'd2100;
    localparam logic [12:0] WAIT_FIRST    = 13'd5100;
    localparam logic [12:0] WAIT_WAKE     = 13'd250;

    localparam int STEP_W     = 4;
    localparam int INIT_STEPS = 12;
    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_STEPS - 1);
    localparam logic [STEP_W-1:0] BYTE_LAST = STEP_W'(1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic       rs;
        logic [7:0] value;
        logic [5:0] col;
        logic [1:0] row;
        logic       display_on;
    } t_request;

    typedef struct packed {
        logic        rs_level;
        logic [3:0]  nibble;
        logic [15:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
        logic       long_wait;
    } t_job;

    function automatic t_result init_strobe(input logic [STEP_W-1:0] step);
        t_result s;
        s.rs_level       = 1'b0;
        s.wait_before_us = WAIT_NONE_B;
        s.wait_after_us  = WAIT_BASE;
        s.last           = 1'b0;
        case (step)
            4'd0: begin
                s.nibble         = 4'h3;
                s.wait_before_us = WAIT_POWER_UP;
                s.wait_after_us  = WAIT_FIRST;
            end
            4'd1, 4'd2: begin
                s.nibble        = 4'h3;
                s.wait_after_us = WAIT_WAKE;
            end
            4'd3: begin
                s.nibble        = 4'h2;
                s.wait_after_us = WAIT_WAKE;
            end
            4'd4:  s.nibble = 4'h2;
            4'd5:  s.nibble = 4'h8;
            4'd6:  s.nibble = 4'h0;
            4'd7:  s.nibble = 4'hC;
            4'd8:  s.nibble = 4'h0;
            4'd9:  s.nibble = 4'h6;
            4'd10: s.nibble = 4'h0;
            4'd11: begin
                s.nibble        = 4'h1;
                s.wait_after_us = WAIT_LONG;
                s.last          = 1'b1;
            end
            default: s.nibble = 4'h0;
        endcase
        return s;
    endfunction

endpackage

[sv/clns_front.sv]
// ----------------------------------------------------------------------------
// clns_front
// Classifies each accepted request into a job for the strobe expander and
// keeps the display control bits.
// ----------------------------------------------------------------------------
module clns_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  clns_pkg::t_request i_request,
    output clns_pkg::t_job    o_job
);

    logic [2:0] r_display_control;
    logic [2:0] n_display_control;
    logic       row_sel;
    logic [6:0] addr;

    always_comb begin
        n_display_control = r_display_control;
        row_sel           = (i_request.row != 2'd0);
        addr              = 7'(i_request.col) + (row_sel ? clns_pkg::ROW_OFFSET : 7'h00);
        o_job.is_init     = 1'b0;
        o_job.rs          = 1'b0;
        o_job.data        = i_request.value;
        o_job.long_wait   = 1'b0;
        case (i_request.kind)
            clns_pkg::KIND_WRITE: begin
                o_job.rs        = i_request.rs;
                o_job.long_wait = !i_request.rs &&
                    (i_request.value inside {clns_pkg::CMD_CLEAR, clns_pkg::CMD_HOME});
            end
            clns_pkg::KIND_INIT: begin
                o_job.is_init     = 1'b1;
                n_display_control = clns_pkg::DC_DISP_ON;
            end
            clns_pkg::KIND_CURSOR: begin
                o_job.data = {1'b1, addr};
            end
            clns_pkg::KIND_DISPLAY: begin
                n_display_control = i_request.display_on
                    ? (r_display_control | clns_pkg::DC_DISP_ON)
                    : (r_display_control & clns_pkg::DC_KEEP_MASK);
                o_job.data = clns_pkg::CMD_DISP_CTL | {5'b0, n_display_control};
            end
            default: begin
                o_job.rs = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_control <= 3'b000;
        end else if (i_accept) begin
            r_display_control <= n_display_control;
        end
    end

endmodule

[sv/clns_queue.sv]
// ----------------------------------------------------------------------------
// clns_queue
// Short job queue between the classifier and the strobe expander.
// ----------------------------------------------------------------------------
module clns_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  clns_pkg::t_job i_job,
    input  logic           i_rd,
    output clns_pkg::t_job o_job,
    output logic           o_valid,
    output logic           o_full
);

    clns_pkg::t_job                  r_slot [clns_pkg::QUEUE_DEPTH];
    logic [clns_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [clns_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [clns_pkg::QUEUE_CW-1:0]   r_count;
    logic [clns_pkg::QUEUE_CW-1:0]   n_count;

    assign o_job   = r_slot[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == clns_pkg::QUEUE_CW'(clns_pkg::QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && !i_rd |-> !o_full)
        else $error("Job queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("Job queue read while empty.");

endmodule

[sv/clns_back.sv]
// ----------------------------------------------------------------------------
// clns_back
// Expands queued jobs into nibble strobes, one per cycle, into an output
// register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module clns_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clns_pkg::t_job    i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_valid,
    output clns_pkg::t_result o_result
);

    logic [clns_pkg::STEP_W-1:0] r_step;
    logic                        r_valid;
    clns_pkg::t_result           r_result;
    clns_pkg::t_result           n_result;
    logic                        step_last;
    logic                        advance;

    always_comb begin
        step_last = i_job.is_init ? (r_step == clns_pkg::INIT_LAST)
                                  : (r_step == clns_pkg::BYTE_LAST);
        if (i_job.is_init) begin
            n_result = clns_pkg::init_strobe(r_step);
        end else begin
            n_result.rs_level       = i_job.rs;
            n_result.nibble         = r_step[0] ? i_job.data[3:0] : i_job.data[7:4];
            n_result.wait_before_us = clns_pkg::WAIT_NONE_B;
            n_result.wait_after_us  = (r_step[0] && i_job.long_wait)
                                      ? clns_pkg::WAIT_LONG : clns_pkg::WAIT_BASE;
            n_result.last           = step_last;
        end
    end

    assign advance   = i_job_valid && (!r_valid || i_pop);
    assign o_job_pop = advance && step_last;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_step  <= step_last ? '0 : r_step + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= clns_pkg::INIT_LAST)
        else $error("Strobe step beyond the power-on sequence.");

    a_step_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_step == '0) && r_valid && r_result.last)
        else $error("Finished job did not end on a final strobe.");

endmodule

[sv/char_lcd_nibble_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns character LCD requests into timed 4-bit enable strobes.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port: a request is taken at a clock
// edge with push high and full low. Kind 0 writes a byte, kind 1 runs the
// power-on sequence, kind 2 sets the cursor address, and kind 3 switches the
// display on or off. Each request is classified at once and placed in a
// four-entry job queue, so several requests can be taken back to back.
// The strobe expander emits one strobe per cycle into an output register
// unless the receiver stalls: a byte request yields two strobes, the
// power-on request twelve strobes, as counted by the step counter of the
// expander. The first strobe of a request passes through the job queue and
// then the output register before it is visible. Results are read while empty
// is low and taken at an edge with pop high; while pop stays low the strobe
// holds and the job queue absorbs new requests until full rises. The last
// field marks the final strobe of each request. Reset empties the job queue,
// the output register and clears the display control bits.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  clns_pkg::t_request i_request,
    output logic               empty,
    input  logic               pop,
    output clns_pkg::t_result  o_result
);

    clns_pkg::t_job front_job;
    clns_pkg::t_job queue_job;
    logic           accept;
    logic           queue_valid;
    logic           queue_full;
    logic           job_pop;
    logic           out_valid;

    assign accept = push && !queue_full;
    assign full   = queue_full;
    assign empty  = !out_valid;

    clns_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_request (i_request),
        .o_job     (front_job)
    );

    clns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_job   (front_job),
        .i_rd    (job_pop),
        .o_job   (queue_job),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    clns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_job_pop   (job_pop),
        .i_pop       (pop && out_valid),
        .o_valid     (out_valid),
        .o_result    (o_result)
    );

endmodule
